// ----- rtl/pbd_pkg.sv -----
// ----------------------------------------------------------------------------
// pbd_pkg
// Shared types, register indexes and helpers of the bilateral point denoiser.
// ----------------------------------------------------------------------------
package pbd_pkg;

   // Configuration register indexes.
   localparam int unsigned CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_DIST_SCALE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NORMAL_SCALE = 2'd1;
   localparam logic [23:0] SCALE_RESET = 24'd65536;

   // Queue between the front and the back.
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

   // Quotient bits produced by the restoring divider.
   localparam logic [5:0] DIV_STEPS = 6'd48;

   typedef struct packed {
      logic [23:0] dist_scale;
      logic [23:0] normal_scale;
   } cfg_type;

   typedef struct packed {
      logic [15:0]        w;
      logic signed [27:0] p;
      logic signed [23:0] cx;
      logic signed [23:0] cy;
      logic signed [23:0] cz;
      logic signed [15:0] nx;
      logic signed [15:0] ny;
      logic signed [15:0] nz;
      logic [15:0]        cw;
      logic               last;
   } entry_type;

   typedef struct packed {
      logic                full;
      logic                empty;
      logic [QCOUNT_W-1:0] count;
   } qstat_type;

   typedef enum logic [3:0] {
      F_IDLE, F_DX, F_DY, F_DZ, F_PX, F_PY, F_PZ, F_PRND, F_PSQ, F_AD, F_AN, F_IDX, F_PUSH
   } front_state_type;

   typedef enum logic [3:0] {
      B_IDLE, B_CHECK, B_DIV, B_SIGN, B_MOVE, B_SX, B_SY, B_SZ, B_OUT
   } back_state_type;

   // Arithmetic right shift rounding half away from zero.
   function automatic logic signed [45:0] rnd_shr(input logic signed [45:0] v,
                                                  input logic [4:0] s);
      logic [45:0] mag;
      logic [45:0] half;
      logic [45:0] r;
      half = 46'd1 << (s - 5'd1);
      mag  = v[45] ? 46'(-v) : 46'(v);
      r    = (mag + half) >> s;
      return v[45] ? -$signed(r) : $signed(r);
   endfunction

endpackage

// ----- rtl/point_bilateral_denoise.sv -----
// ----------------------------------------------------------------------------
// point_bilateral_denoise
// Bilateral point cloud denoiser, one neighbour item at a time.
// ----------------------------------------------------------------------------
// Flow: the front takes a new item only once it has handed the last one on,
// paced by its single shared multiplier, which it reuses for each product.
// An item that ends a group with non-zero sums holds the back while it divides,
// so the front stalls once the two-entry queue has filled behind it.
// Most of the work for such an item is the 48 step restoring divider in the
// back, which is skipped when a sum is zero.
// Reset is synchronous: sums, counts, queue and handshakes clear at once and
// both scale registers return to 1.0; there is no clearing pass.
// ----------------------------------------------------------------------------
module point_bilateral_denoise #(
   parameter int unsigned MAX_NEIGHBORS     = 64,
   parameter int unsigned EXP_TABLE_ENTRIES = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   // Configuration write channel.
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [pbd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [23:0]                    csr_data,
   // Neighbour items.
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // From bit 0: center_x, center_y, center_z, normal_x, normal_y, normal_z,
   // neighbor_x, neighbor_y, neighbor_z, curve_weight.
   input  logic [207:0]                   req_tdata,
   input  logic                           req_tlast,   // last_neighbor
   // Filtered points.
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // From bit 0: out_x, out_y, out_z.
   output logic [71:0]                    rsp_tdata,
   output logic                           rsp_tuser    // moved
);

   pbd_pkg::cfg_type   cfg_ff;
   pbd_pkg::entry_type push_data, pop_data;
   pbd_pkg::qstat_type q_stat;
   logic               push_valid, push_ready;
   logic               pop_valid, pop_ready;

   // Always ready; user must send writes only while the block is idle (not enforced).
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dist_scale   <= pbd_pkg::SCALE_RESET;
         cfg_ff.normal_scale <= pbd_pkg::SCALE_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            pbd_pkg::CSR_DIST_SCALE:   cfg_ff.dist_scale   <= csr_data;
            pbd_pkg::CSR_NORMAL_SCALE: cfg_ff.normal_scale <= csr_data;
            default: ;
         endcase
      end
   end

   // The front forms offset, squared distance, projection and table weight
   // for each neighbour and hands the result to the queue.
   pbd_front #(
      .EXP_TABLE_ENTRIES(EXP_TABLE_ENTRIES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // The queue lets the front carry on while the back divides.
   pbd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .stat       (q_stat)
   );

   // The back accumulates the sums and, at the end of a group, divides,
   // moves the centre along its normal and holds the result for the output.
   pbd_back #(
      .MAX_NEIGHBORS(MAX_NEIGHBORS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // The queue never holds more entries than it has room for.
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_stat.count <= pbd_pkg::QUEUE_DEPTH)
      else $error("queue occupancy beyond its depth");

   // The front takes a new item only when it has nothing left to hand on.
   a_front_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !push_valid)
      else $error("front accepting while an entry is pending");

   // A full queue always stalls the front.
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (push_valid && q_stat.full) |=> push_valid)
      else $error("front dropped an entry into a full queue");

endmodule

// ----- rtl/pbd_front.sv -----
// ----------------------------------------------------------------------------
// pbd_front
// Accepts neighbour items and works out the range and normal weight of each.
// ----------------------------------------------------------------------------
module pbd_front #(
   parameter int unsigned EXP_TABLE_ENTRIES = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  pbd_pkg::cfg_type    cfg,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [207:0]        req_tdata,
   input  logic                req_tlast,
   output logic                push_valid,
   input  logic                push_ready,
   output pbd_pkg::entry_type  push_data
);

   localparam int unsigned IW = $clog2(EXP_TABLE_ENTRIES);
   localparam int unsigned NW = $clog2(EXP_TABLE_ENTRIES + 1);
   localparam int unsigned PW = 20 + NW;

   // Step factor exp(-16/N) from a series through the twelfth power in Q.32.
   localparam logic [63:0] H   = (64'd16 << 32) / EXP_TABLE_ENTRIES;
   localparam logic [63:0] T0  = 64'd1 << 32;
   localparam logic [63:0] T1  = ((T0 * H) >> 32) / 1;
   localparam logic [63:0] T2  = ((T1 * H) >> 32) / 2;
   localparam logic [63:0] T3  = ((T2 * H) >> 32) / 3;
   localparam logic [63:0] T4  = ((T3 * H) >> 32) / 4;
   localparam logic [63:0] T5  = ((T4 * H) >> 32) / 5;
   localparam logic [63:0] T6  = ((T5 * H) >> 32) / 6;
   localparam logic [63:0] T7  = ((T6 * H) >> 32) / 7;
   localparam logic [63:0] T8  = ((T7 * H) >> 32) / 8;
   localparam logic [63:0] T9  = ((T8 * H) >> 32) / 9;
   localparam logic [63:0] T10 = ((T9 * H) >> 32) / 10;
   localparam logic [63:0] T11 = ((T10 * H) >> 32) / 11;
   localparam logic [63:0] T12 = ((T11 * H) >> 32) / 12;
   localparam logic [63:0] R   = T0 - T1 + T2 - T3 + T4 - T5 + T6 - T7 + T8 - T9 + T10
                                 - T11 + T12;

   function automatic logic [16*EXP_TABLE_ENTRIES-1:0] build_tab(input logic [63:0] r);
      logic [63:0] v;
      logic [63:0] e;
      logic [16*EXP_TABLE_ENTRIES-1:0] t;
      v = 64'd1 << 32;
      t = '0;
      for (int k = 0; k < EXP_TABLE_ENTRIES; k++) begin
         e = (v + 64'd32768) >> 16;
         t[16*k +: 16] = (e > 64'd65535) ? 16'hFFFF : e[15:0];
         v = (v * r + (64'd1 << 31)) >> 32;
      end
      return t;
   endfunction

   localparam logic [16*EXP_TABLE_ENTRIES-1:0] TAB = build_tab(R);

   pbd_pkg::front_state_type state_ff, state_in;

   logic signed [23:0] c_ff [3];
   logic signed [15:0] n_ff [3];
   logic signed [24:0] d_ff [3];
   logic [15:0]        cw_ff;
   logic               last_ff;
   logic [49:0]        d2_ff;
   logic signed [41:0] pr_ff;
   logic signed [27:0] p_ff;
   logic [53:0]        p2_ff;
   logic [62:0]        a_ff;
   logic [IW-1:0]      idx_ff;
   logic               big_ff;

   logic signed [38:0] mul_a;
   logic signed [28:0] mul_b;
   logic signed [67:0] mul_p;
   logic [PW-1:0]      idx_prod;

   assign mul_p    = mul_a * mul_b;
   assign idx_prod = PW'(a_ff[35:16]) * PW'(EXP_TABLE_ENTRIES);

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      push_valid = 1'b0;
      mul_a      = '0;
      mul_b      = '0;
      unique case (state_ff)
         pbd_pkg::F_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) state_in = pbd_pkg::F_DX;
         end
         pbd_pkg::F_DX: begin
            mul_a = 39'(d_ff[0]); mul_b = 29'(d_ff[0]); state_in = pbd_pkg::F_DY;
         end
         pbd_pkg::F_DY: begin
            mul_a = 39'(d_ff[1]); mul_b = 29'(d_ff[1]); state_in = pbd_pkg::F_DZ;
         end
         pbd_pkg::F_DZ: begin
            mul_a = 39'(d_ff[2]); mul_b = 29'(d_ff[2]); state_in = pbd_pkg::F_PX;
         end
         pbd_pkg::F_PX: begin
            mul_a = 39'(d_ff[0]); mul_b = 29'(n_ff[0]); state_in = pbd_pkg::F_PY;
         end
         pbd_pkg::F_PY: begin
            mul_a = 39'(d_ff[1]); mul_b = 29'(n_ff[1]); state_in = pbd_pkg::F_PZ;
         end
         pbd_pkg::F_PZ: begin
            mul_a = 39'(d_ff[2]); mul_b = 29'(n_ff[2]); state_in = pbd_pkg::F_PRND;
         end
         pbd_pkg::F_PRND: state_in = pbd_pkg::F_PSQ;
         pbd_pkg::F_PSQ: begin
            mul_a = 39'(p_ff); mul_b = 29'(p_ff); state_in = pbd_pkg::F_AD;
         end
         pbd_pkg::F_AD: begin
            mul_a    = $signed({5'd0, d2_ff[49:16]});
            mul_b    = $signed({5'd0, cfg.dist_scale});
            state_in = pbd_pkg::F_AN;
         end
         pbd_pkg::F_AN: begin
            mul_a    = $signed({1'b0, p2_ff[53:16]});
            mul_b    = $signed({5'd0, cfg.normal_scale});
            state_in = pbd_pkg::F_IDX;
         end
         pbd_pkg::F_IDX: state_in = pbd_pkg::F_PUSH;
         pbd_pkg::F_PUSH: begin
            push_valid = 1'b1;
            if (push_ready) state_in = pbd_pkg::F_IDLE;
         end
         default: state_in = pbd_pkg::F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= pbd_pkg::F_IDLE;
      else       state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      case (state_ff) inside
         pbd_pkg::F_IDLE: if (req_tvalid) begin
            c_ff[0] <= req_tdata[23:0];
            c_ff[1] <= req_tdata[47:24];
            c_ff[2] <= req_tdata[71:48];
            n_ff[0] <= req_tdata[87:72];
            n_ff[1] <= req_tdata[103:88];
            n_ff[2] <= req_tdata[119:104];
            d_ff[0] <= 25'($signed(req_tdata[143:120])) - 25'($signed(req_tdata[23:0]));
            d_ff[1] <= 25'($signed(req_tdata[167:144])) - 25'($signed(req_tdata[47:24]));
            d_ff[2] <= 25'($signed(req_tdata[191:168])) - 25'($signed(req_tdata[71:48]));
            cw_ff   <= req_tdata[207:192];
            last_ff <= req_tlast;
         end
         pbd_pkg::F_DX:                 d2_ff <= mul_p[49:0];
         pbd_pkg::F_DY, pbd_pkg::F_DZ:  d2_ff <= d2_ff + mul_p[49:0];
         pbd_pkg::F_PX:                 pr_ff <= mul_p[41:0];
         pbd_pkg::F_PY, pbd_pkg::F_PZ:  pr_ff <= pr_ff + mul_p[41:0];
         pbd_pkg::F_PRND: p_ff <= 28'(pbd_pkg::rnd_shr(46'(pr_ff), 5'd14));
         pbd_pkg::F_PSQ:  p2_ff <= mul_p[53:0];
         pbd_pkg::F_AD:   a_ff <= mul_p[62:0];
         pbd_pkg::F_AN:   a_ff <= a_ff + mul_p[62:0];
         pbd_pkg::F_IDX: begin
            // An argument of 16.0 or more gives no weight.
            big_ff <= |a_ff[62:36];
            idx_ff <= IW'(idx_prod >> 20);
         end
         default: ;
      endcase
   end

   always_comb begin
      push_data.w    = big_ff ? 16'd0 : TAB[idx_ff*16 +: 16];
      push_data.p    = p_ff;
      push_data.cx   = c_ff[0];
      push_data.cy   = c_ff[1];
      push_data.cz   = c_ff[2];
      push_data.nx   = n_ff[0];
      push_data.ny   = n_ff[1];
      push_data.nz   = n_ff[2];
      push_data.cw   = cw_ff;
      push_data.last = last_ff;
   end

endmodule

// ----- rtl/pbd_queue.sv -----
// ----------------------------------------------------------------------------
// pbd_queue
// Short first-in first-out queue of weighted neighbour entries.
// ----------------------------------------------------------------------------
module pbd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  pbd_pkg::entry_type  push_data,
   output logic                pop_valid,
   input  logic                pop_ready,
   output pbd_pkg::entry_type  pop_data,
   output pbd_pkg::qstat_type  stat
);

   pbd_pkg::entry_type                 mem_ff [pbd_pkg::QUEUE_DEPTH];
   logic [pbd_pkg::QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [pbd_pkg::QCOUNT_W-1:0] count_ff;
   logic                         do_push, do_pop;

   assign stat.full  = (count_ff == pbd_pkg::QCOUNT_W'(pbd_pkg::QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign stat.count = count_ff;
   assign push_ready = !stat.full;
   assign pop_valid  = !stat.empty;
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == pbd_pkg::QPTR_W'(pbd_pkg::QUEUE_DEPTH - 1))
                         ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == pbd_pkg::QPTR_W'(pbd_pkg::QUEUE_DEPTH - 1))
                         ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop)      count_ff <= count_ff + 1'b1;
         else if (do_pop && !do_push) count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_data;
   end

endmodule

// ----- rtl/pbd_back.sv -----
// ----------------------------------------------------------------------------
// pbd_back
// Accumulates weights, divides at the end of a group and moves the centre.
// ----------------------------------------------------------------------------
module pbd_back #(
   parameter int unsigned MAX_NEIGHBORS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  pbd_pkg::entry_type pop_data,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [71:0]        rsp_tdata,
   output logic               rsp_tuser
);

   localparam int unsigned CW = $clog2(MAX_NEIGHBORS + 1);

   function automatic logic [23:0] sat24(input logic signed [30:0] v);
      if (v > 31'sd8388607)       return 24'h7FFFFF;
      else if (v < -31'sd8388608) return 24'h800000;
      else                        return v[23:0];
   endfunction

   pbd_pkg::back_state_type state_ff, state_in;

   logic [23:0]        ws_ff;
   logic signed [47:0] lam_ff;
   logic [CW-1:0]      cnt_ff;
   logic signed [23:0] c_ff [3];
   logic signed [15:0] n_ff [3];
   logic [15:0]        cw_ff;
   logic [23:0]        div_rem_ff;
   logic [47:0]        div_q_ff;
   logic [23:0]        div_dsr_ff;
   logic [5:0]         div_cnt_ff;
   logic               div_neg_ff;
   logic signed [28:0] q_ff;
   logic signed [28:0] mv_ff;
   logic signed [23:0] o_ff [3];
   logic               moved_ff;
   logic               rsp_valid_ff;
   logic [71:0]        rsp_data_ff;
   logic               rsp_user_ff;

   logic signed [28:0] mul_a;
   logic signed [16:0] mul_b;
   logic signed [45:0] mul_p;
   logic [24:0]        ws_sum;
   logic signed [48:0] lam_sum;
   logic [24:0]        rem2;
   logic               ge;
   logic               rsp_free;

   assign mul_p    = mul_a * mul_b;
   assign ws_sum   = {1'b0, ws_ff} + 25'(pop_data.w);
   assign lam_sum  = 49'(lam_ff) + 49'(mul_p);
   assign rem2     = {div_rem_ff, div_q_ff[47]};
   assign ge       = (rem2 >= {1'b0, div_dsr_ff});
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in  = state_ff;
      pop_ready = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      unique case (state_ff)
         pbd_pkg::B_IDLE: begin
            pop_ready = 1'b1;
            mul_a     = 29'(pop_data.p);
            mul_b     = $signed({1'b0, pop_data.w});
            if (pop_valid && pop_data.last) state_in = pbd_pkg::B_CHECK;
         end
         pbd_pkg::B_CHECK: begin
            if (ws_ff == '0 || lam_ff == '0) state_in = pbd_pkg::B_OUT;
            else                             state_in = pbd_pkg::B_DIV;
         end
         pbd_pkg::B_DIV: if (div_cnt_ff == 6'd1) state_in = pbd_pkg::B_SIGN;
         pbd_pkg::B_SIGN: state_in = pbd_pkg::B_MOVE;
         pbd_pkg::B_MOVE: begin
            mul_a = q_ff; mul_b = $signed({1'b0, cw_ff}); state_in = pbd_pkg::B_SX;
         end
         pbd_pkg::B_SX: begin
            mul_a = mv_ff; mul_b = 17'(n_ff[0]); state_in = pbd_pkg::B_SY;
         end
         pbd_pkg::B_SY: begin
            mul_a = mv_ff; mul_b = 17'(n_ff[1]); state_in = pbd_pkg::B_SZ;
         end
         pbd_pkg::B_SZ: begin
            mul_a = mv_ff; mul_b = 17'(n_ff[2]); state_in = pbd_pkg::B_OUT;
         end
         pbd_pkg::B_OUT: if (rsp_free) state_in = pbd_pkg::B_IDLE;
         default: state_in = pbd_pkg::B_IDLE;
      endcase
   end

   // Control state and sums.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pbd_pkg::B_IDLE;
         ws_ff        <= '0;
         lam_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == pbd_pkg::B_IDLE && pop_valid && cnt_ff < CW'(MAX_NEIGHBORS)) begin
            cnt_ff <= cnt_ff + 1'b1;
            ws_ff  <= ws_sum[24] ? 24'hFFFFFF : ws_sum[23:0];
            if (lam_sum[48] != lam_sum[47])
               lam_ff <= lam_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
            else
               lam_ff <= lam_sum[47:0];
         end else if (state_ff == pbd_pkg::B_CHECK) begin
            ws_ff  <= '0;
            lam_ff <= '0;
            cnt_ff <= '0;
         end
         if (state_ff == pbd_pkg::B_OUT && rsp_free) rsp_valid_ff <= 1'b1;
         else if (rsp_tready)                        rsp_valid_ff <= 1'b0;
      end
   end

   // Datapath.
   always_ff @(posedge clock) begin
      case (state_ff)
         pbd_pkg::B_IDLE: if (pop_valid) begin
            c_ff[0] <= pop_data.cx;
            c_ff[1] <= pop_data.cy;
            c_ff[2] <= pop_data.cz;
            n_ff[0] <= pop_data.nx;
            n_ff[1] <= pop_data.ny;
            n_ff[2] <= pop_data.nz;
            cw_ff   <= pop_data.cw;
         end
         pbd_pkg::B_CHECK: begin
            if (ws_ff == '0 || lam_ff == '0) begin
               o_ff[0]  <= c_ff[0];
               o_ff[1]  <= c_ff[1];
               o_ff[2]  <= c_ff[2];
               moved_ff <= 1'b0;
            end else begin
               div_rem_ff <= '0;
               div_q_ff   <= lam_ff[47] ? 48'(-lam_ff) : 48'(lam_ff);
               div_neg_ff <= lam_ff[47];
               div_dsr_ff <= ws_ff;
               div_cnt_ff <= pbd_pkg::DIV_STEPS;
               moved_ff   <= 1'b1;
            end
         end
         pbd_pkg::B_DIV: begin
            div_rem_ff <= ge ? 24'(rem2 - {1'b0, div_dsr_ff}) : rem2[23:0];
            div_q_ff   <= {div_q_ff[46:0], ge};
            div_cnt_ff <= div_cnt_ff - 1'b1;
         end
         // The mean projection never exceeds the largest projection, so 29 bits hold it.
         pbd_pkg::B_SIGN: q_ff <= div_neg_ff ? -$signed(div_q_ff[28:0]) : $signed(div_q_ff[28:0]);
         pbd_pkg::B_MOVE: mv_ff <= 29'(pbd_pkg::rnd_shr(mul_p, 5'd16));
         pbd_pkg::B_SX: o_ff[0] <= sat24(31'(c_ff[0]) + 31'(pbd_pkg::rnd_shr(mul_p, 5'd14)));
         pbd_pkg::B_SY: o_ff[1] <= sat24(31'(c_ff[1]) + 31'(pbd_pkg::rnd_shr(mul_p, 5'd14)));
         pbd_pkg::B_SZ: o_ff[2] <= sat24(31'(c_ff[2]) + 31'(pbd_pkg::rnd_shr(mul_p, 5'd14)));
         pbd_pkg::B_OUT: if (rsp_free) begin
            rsp_data_ff <= {o_ff[2], o_ff[1], o_ff[0]};
            rsp_user_ff <= moved_ff;
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ----- tb/sv/point_bilateral_denoise_check.sv -----
// ----------------------------------------------------------------------------
// point_bilateral_denoise_check
// Watches the configuration, neighbour and result channels of the denoiser,
// predicts every filtered point and compares it with what the block emits.
// ----------------------------------------------------------------------------
module point_bilateral_denoise_check (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [pbd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [23:0]                   csr_data,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [207:0]                  req_tdata,
   input  logic                          req_tlast,
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [71:0]                   rsp_tdata,
   input  logic                          rsp_tuser,
   output int                            error_count,
   output int                            pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  LUT_SIZE  = 256;
   localparam int  MAX_NBRS  = 64;
   localparam longint LAMBDA_MAX = 64'sh7FFF_FFFF_FFFF;
   localparam longint LAMBDA_MIN = -LAMBDA_MAX - 1;

   typedef struct packed {
      logic [71:0] xyz;
      logic        moved;
   } filtered_point_type;

   filtered_point_type filtered_q[$];
   longint             exp_lut[LUT_SIZE];
   logic [23:0]        dist_scale_q;
   logic [23:0]        normal_scale_q;
   longint             weight_acc;
   longint             lambda_acc;
   int                 nbr_seen;

   // Weight table: exp(-16k/N) by repeated multiplication with a series
   // approximation of exp(-16/N), all in Q.32.
   initial begin
      bit [63:0] step_h, term, ratio, v, e;
      step_h = (64'd16 << 32) / LUT_SIZE;
      term   = 64'd1 << 32;
      ratio  = term;
      for (int n = 1; n <= 12; n++) begin
         term = ((term * step_h) >> 32) / n;
         if (n % 2 == 1) ratio = ratio - term;
         else ratio = ratio + term;
      end
      v = 64'd1 << 32;
      for (int k = 0; k < LUT_SIZE; k++) begin
         e = (v + 64'd32768) >> 16;
         exp_lut[k] = (e > 64'd65535) ? 65535 : longint'(e);
         v = (v * ratio + (64'd1 << 31)) >> 32;
      end
      error_count = 0;
      pending = 0;
   end

   function automatic longint round_shift(longint v, int s);
      longint half;
      half = longint'(1) << (s - 1);
      if (v < 0) return -((-v + half) >>> s);
      return (v + half) >>> s;
   endfunction

   function automatic longint clamp24(longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return v;
   endfunction

   task automatic report(string what, longint want, longint got);
      $display("MISMATCH %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
      error_count++;
   endtask

   // Accumulates one neighbour and, on the last one, queues the filtered point.
   task automatic accumulate_neighbour(logic [207:0] td, logic last);
      longint c[3], n[3], d[3];
      longint p, d2, p2, arg, w, l, q, mv, o;
      longint cw;
      filtered_point_type fp;
      c[0] = $signed(td[23:0]);
      c[1] = $signed(td[47:24]);
      c[2] = $signed(td[71:48]);
      n[0] = $signed(td[87:72]);
      n[1] = $signed(td[103:88]);
      n[2] = $signed(td[119:104]);
      d[0] = longint'($signed(td[143:120])) - c[0];
      d[1] = longint'($signed(td[167:144])) - c[1];
      d[2] = longint'($signed(td[191:168])) - c[2];
      cw   = longint'({48'd0, td[207:192]});
      d2 = 0;
      p  = 0;
      for (int i = 0; i < 3; i++) begin
         d2 += d[i] * d[i];
         p  += n[i] * d[i];
      end
      p   = round_shift(p, 14);
      p2  = p * p;
      arg = ((d2 >> 16) * longint'({40'd0, dist_scale_q})
             + (p2 >> 16) * longint'({40'd0, normal_scale_q})) >> 16;
      w   = (arg < (longint'(1) << 20)) ? exp_lut[(arg * LUT_SIZE) >> 20] : 0;

      // Neighbours past the limit of a group are ignored.
      if (nbr_seen < MAX_NBRS) begin
         nbr_seen++;
         weight_acc += w;
         if (weight_acc > 64'hFF_FFFF) weight_acc = 64'hFF_FFFF;
         l = lambda_acc + w * p;
         if (l > LAMBDA_MAX) l = LAMBDA_MAX;
         if (l < LAMBDA_MIN) l = LAMBDA_MIN;
         lambda_acc = l;
      end
      if (!last) return;

      if (weight_acc == 0 || lambda_acc == 0) begin
         fp.xyz   = {c[2][23:0], c[1][23:0], c[0][23:0]};
         fp.moved = 1'b0;
      end else begin
         q  = lambda_acc / weight_acc;
         mv = round_shift(q * cw, 16);
         for (int i = 0; i < 3; i++) begin
            o = clamp24(c[i] + round_shift(mv * n[i], 14));
            fp.xyz[i*24 +: 24] = o[23:0];
         end
         fp.moved = 1'b1;
      end
      filtered_q.push_back(fp);
      weight_acc = 0;
      lambda_acc = 0;
      nbr_seen   = 0;
   endtask

   always @(posedge clock) begin
      filtered_point_type want;
      if (reset) begin
         dist_scale_q   <= pbd_pkg::SCALE_RESET;
         normal_scale_q <= pbd_pkg::SCALE_RESET;
         weight_acc = 0;
         lambda_acc = 0;
         nbr_seen   = 0;
         filtered_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (filtered_q.size() == 0) begin
               report("unexpected point", 0, 1);
            end else begin
               want = filtered_q.pop_front();
               if (rsp_tdata[23:0] !== want.xyz[23:0])
                  report("out_x", $signed(want.xyz[23:0]), $signed(rsp_tdata[23:0]));
               if (rsp_tdata[47:24] !== want.xyz[47:24])
                  report("out_y", $signed(want.xyz[47:24]), $signed(rsp_tdata[47:24]));
               if (rsp_tdata[71:48] !== want.xyz[71:48])
                  report("out_z", $signed(want.xyz[71:48]), $signed(rsp_tdata[71:48]));
               if (rsp_tuser !== want.moved)
                  report("moved", want.moved, rsp_tuser);
            end
         end
         if (req_tvalid && req_tready)
            accumulate_neighbour(req_tdata, req_tlast);
         if (csr_valid && csr_ready) begin
            if (csr_index == pbd_pkg::CSR_DIST_SCALE) dist_scale_q <= csr_data;
            else if (csr_index == pbd_pkg::CSR_NORMAL_SCALE) normal_scale_q <= csr_data;
         end
      end
      pending = filtered_q.size();
   end

endmodule

// ----- tb/sv/point_bilateral_denoise_test.sv -----
// ----------------------------------------------------------------------------
// point_bilateral_denoise_test
// Drives neighbour groups through the denoiser under several scale settings,
// with bursty input and a stalling receiver; the checker judges the results.
// ----------------------------------------------------------------------------
module point_bilateral_denoise_test;
   timeunit 1ns;
   timeprecision 1ps;

   // The limit leaves a wide margin over the length of the slowest run.
   localparam int CYCLE_LIMIT = 1_000_000;
   // Extra wait after the last expected point, so that the block is quiet.
   localparam int DRAIN_CYCLES = 150;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [pbd_pkg::CSR_IDX_W-1:0] csr_index = pbd_pkg::CSR_DIST_SCALE;
   logic [23:0]                   csr_data = '0;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [207:0]                  req_tdata = '0;
   logic                          req_tlast = 1'b0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [71:0]                   rsp_tdata;
   logic                          rsp_tuser;
   int                            error_count;
   int                            pending;
   int                            cycle_count = 0;
   int                            burst_left = 0;
   int                            stall_mode = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   point_bilateral_denoise dut (
      .clock, .reset,
      .csr_valid, .csr_ready, .csr_index, .csr_data,
      .req_tvalid, .req_tready, .req_tdata, .req_tlast,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser
   );

   point_bilateral_denoise_check checker_i (
      .clock, .reset,
      .csr_valid, .csr_ready, .csr_index, .csr_data,
      .req_tvalid, .req_tready, .req_tdata, .req_tlast,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .error_count, .pending
   );

   // The run is cut short if the block hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // The receiver draws its stall pattern at random: always ready, ready half
   // the time, mostly stalled, or alternating.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (cycle_count % 256 == 0) stall_mode = $urandom_range(0, 3);
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            2: rsp_tready <= ($urandom_range(0, 4) == 0);
            default: rsp_tready <= cycle_count[0];
         endcase
      end
   end

   // Sends one neighbour item. The sender works in bursts; between bursts it
   // usually drops valid for a random gap.
   task automatic send_neighbour(logic [23:0] cx, logic [23:0] cy, logic [23:0] cz,
                                 logic [15:0] nx, logic [15:0] ny, logic [15:0] nz,
                                 logic [23:0] bx, logic [23:0] by, logic [23:0] bz,
                                 logic [15:0] cw, logic last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {cw, bz, by, bx, nz, ny, nx, cz, cy, cx};
      req_tlast  <= last;
      forever begin
         @(negedge clock);
         if (req_tready) break;
         @(posedge clock);
      end
      @(posedge clock);
   endtask

   // Waits until every expected point has come and the block is quiet.
   task automatic drain;
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Valid drops after each write, so back-to-back writes never run
   // together.
   task automatic write_scale(logic [pbd_pkg::CSR_IDX_W-1:0] idx, logic [23:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      forever begin
         @(negedge clock);
         if (csr_ready) break;
         @(posedge clock);
      end
      @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [23:0] random_scale();
      case ($urandom_range(0, 5))
         0: return 24'd0;
         1: return 24'hFF_FFFF;
         2: return 24'($urandom_range(1, 256));
         3: return 24'($urandom_range(1 << 14, 1 << 18));
         default: return 24'($urandom());
      endcase
   endfunction

   // A unit-ish normal component; now and then any 16-bit pattern.
   function automatic logic [15:0] random_normal();
      if ($urandom_range(0, 9) == 0) return 16'($urandom());
      return 16'($signed($urandom_range(0, 32768)) - 16384);
   endfunction

   // A neighbour coordinate close to the centre, or anywhere at all.
   function automatic logic [23:0] near_coord(logic [23:0] centre);
      int span;
      if ($urandom_range(0, 7) == 0) return 24'($urandom());
      case ($urandom_range(0, 3))
         0: span = 256;
         1: span = 4096;
         2: span = 65536;
         default: span = 262144;
      endcase
      return centre + 24'($signed($urandom_range(0, 2 * span)) - span);
   endfunction

   initial begin
      logic [23:0] cx, cy, cz;
      logic [15:0] nx, ny, nz, cw;
      int group_len;
      int sent;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, at the reset scales of 1.0.
      // A neighbour on the centre: weight but no projection, so the point
      // passes unchanged.
      send_neighbour(24'd1000, 24'd2000, 24'd3000, 16'sd0, 16'sd0, 16'sd16384,
                     24'd1000, 24'd2000, 24'd3000, 16'hFFFF, 1'b1);
      // Far neighbour: the argument exceeds the table and the weight is zero.
      send_neighbour(24'h7F_FFFF, 24'h7F_FFFF, 24'h7F_FFFF, 16'sd16384, 16'sd0, 16'sd0,
                     24'h80_0000, 24'h80_0000, 24'h80_0000, 16'hFFFF, 1'b1);
      // Small offsets along the normal, both signs, one group of three.
      send_neighbour(24'd0, 24'd0, 24'd0, 16'sd0, 16'sd0, 16'sd16384,
                     24'd0, 24'd0, 24'd20000, 16'hFFFF, 1'b0);
      send_neighbour(24'd0, 24'd0, 24'd0, 16'sd0, 16'sd0, 16'sd16384,
                     24'd100, 24'd0, 24'd30000, 16'hFFFF, 1'b0);
      send_neighbour(24'd0, 24'd0, 24'd0, 16'sd0, 16'sd0, 16'sd16384,
                     24'd0, 24'd50, 24'hFF_F000, 16'hFFFF, 1'b1);
      // Negative normal limits and out-of-range normal patterns.
      send_neighbour(24'h80_0000, 24'h00_0100, 24'h7F_FF00, 16'h8000, 16'hC000, 16'h7FFF,
                     24'h80_1000, 24'h00_0000, 24'h7F_FFFF, 16'd0, 1'b1);
      send_neighbour(24'h7F_FFF0, 24'h80_0010, 24'h00_0000, 16'sd16384, 16'hC000, 16'sd0,
                     24'h7F_FFFF, 24'h80_0000, 24'h00_1000, 16'hFFFF, 1'b1);
      // The centre changes inside a group; the last one forms the result.
      send_neighbour(24'd5000, 24'd5000, 24'd5000, 16'sd16384, 16'sd0, 16'sd0,
                     24'd15000, 24'd5000, 24'd5000, 16'd100, 1'b0);
      send_neighbour(24'd7000, 24'd6000, 24'd5000, 16'sd0, 16'sd16384, 16'sd0,
                     24'd7000, 24'd16000, 24'd5000, 16'h8000, 1'b1);
      // A group longer than the neighbour limit.
      for (int i = 0; i < 70; i++)
         send_neighbour(24'd0, 24'd0, 24'd0, 16'sd0, 16'sd16384, 16'sd0,
                        24'(i * 37), 24'(i * 500 - 20000), 24'd0, 16'hFFFF, 1'(i == 69));

      // Random part, in phases of different scale settings. The first two
      // phases take both extremes; a zero scale gives full weight to every
      // neighbour, which can drive the projection sum and the outputs into saturation.
      sent = 0;
      for (int phase = 0; phase < 7; phase++) begin
         drain();
         case (phase)
            0: begin
               write_scale(pbd_pkg::CSR_DIST_SCALE, 24'd0);
               write_scale(pbd_pkg::CSR_NORMAL_SCALE, 24'd0);
            end
            1: begin
               write_scale(pbd_pkg::CSR_DIST_SCALE, 24'hFF_FFFF);
               write_scale(pbd_pkg::CSR_NORMAL_SCALE, 24'hFF_FFFF);
            end
            2: begin
               write_scale(pbd_pkg::CSR_DIST_SCALE, pbd_pkg::SCALE_RESET);
               write_scale(pbd_pkg::CSR_NORMAL_SCALE, pbd_pkg::SCALE_RESET);
            end
            default: begin
               write_scale(pbd_pkg::CSR_DIST_SCALE, random_scale());
               write_scale(pbd_pkg::CSR_NORMAL_SCALE, random_scale());
            end
         endcase
         while (sent < (phase + 1) * 225) begin
            // Mostly short groups about one centre; now and then a long one.
            group_len = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70)
                                                     : $urandom_range(1, 8);
            cx = 24'($urandom());
            cy = 24'($urandom());
            cz = 24'($urandom());
            nx = random_normal();
            ny = random_normal();
            nz = random_normal();
            cw = ($urandom_range(0, 4) == 0) ? 16'hFFFF : 16'($urandom());
            for (int i = 0; i < group_len; i++) begin
               // Occasional noise: a centre and a normal that drift inside the group.
               if ($urandom_range(0, 15) == 0) begin
                  cx = 24'($urandom());
                  nz = random_normal();
               end
               send_neighbour(cx, cy, cz, nx, ny, nz,
                              near_coord(cx), near_coord(cy), near_coord(cz),
                              cw, 1'(i == group_len - 1));
               sent++;
            end
         end
      end

      drain();
      if (error_count == 0 && pending == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
